### rtl/tolerance_flood_fill_assert.svh
// Assertion macros for the flood fill block.
`ifndef TOLERANCE_FLOOD_FILL_ASSERT_SVH
`define TOLERANCE_FLOOD_FILL_ASSERT_SVH

// Condition must hold in the same cycle.
`define TFF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the next cycle.
`define TFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tff_pkg.sv
`default_nettype none

package tff_pkg;

    localparam int IMG_WIDTH_DEF  = 64;
    localparam int IMG_HEIGHT_DEF = 64;

    localparam int REQ_W      = 2;
    localparam int COORD_W    = 6;
    localparam int PIX_W      = 32;
    localparam int CNT_W      = 13;
    localparam int CNT_MAX    = 8191;
    localparam int CHAN_W     = 8;
    localparam int CHAN_N     = 4;
    localparam int TOL_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FILL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'd1;

    typedef logic [REQ_W-1:0]   t_req_type;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [PIX_W-1:0]   t_pixel;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [TOL_W-1:0]   t_tol;

    typedef struct packed {
        logic      start;
        t_req_type req_type;
        t_coord    x;
        t_coord    y;
        t_pixel    pixel;
    } t_cmd;

    typedef struct packed {
        logic   done;
        t_pixel pixel;
        t_count count;
    } t_rsp;

endpackage

`default_nettype wire

### rtl/tff_req_if.sv
`default_nettype none

interface tff_req_if;
    import tff_pkg::*;

    logic      valid;
    logic      ready;
    t_req_type req_type;
    t_coord    x_coord;
    t_coord    y_coord;
    t_pixel    pixel_in;

    modport source (output valid, output req_type, output x_coord, output y_coord,
                    output pixel_in, input ready);
    modport sink   (input valid, input req_type, input x_coord, input y_coord,
                    input pixel_in, output ready);
endinterface

`default_nettype wire

### rtl/tff_rsp_if.sv
`default_nettype none

interface tff_rsp_if;
    import tff_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel pixel_out;
    t_count painted_count;

    modport source (output valid, output pixel_out, output painted_count, input ready);
    modport sink   (input valid, input pixel_out, input painted_count, output ready);
endinterface

`default_nettype wire

### rtl/tff_join_cmp.sv
`default_nettype none

module tff_join_cmp (
    input  tff_pkg::t_pixel i_pixel,
    input  tff_pkg::t_pixel i_ref,
    input  tff_pkg::t_tol   i_tolerance,
    output logic            o_join
);
    import tff_pkg::*;

    logic [CHAN_N-1:0] chan_ok;

    for (genvar g = 0; g < CHAN_N; g++) begin : g_chan
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] diff;
        assign a          = i_pixel[g*CHAN_W +: CHAN_W];
        assign b          = i_ref[g*CHAN_W +: CHAN_W];
        assign diff       = (a > b) ? (a - b) : (b - a);
        assign chan_ok[g] = (diff <= i_tolerance);
    end

    assign o_join = &chan_ok;

endmodule

`default_nettype wire

### rtl/tff_fill_engine.sv
`default_nettype none

module tff_fill_engine #(
    parameter int IMG_WIDTH  = tff_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = tff_pkg::IMG_HEIGHT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tff_pkg::t_cmd   i_cmd,
    input  tff_pkg::t_pixel i_fill_color,
    input  tff_pkg::t_tol   i_tolerance,
    output logic            o_busy,
    output tff_pkg::t_rsp   o_rsp
);
    import tff_pkg::*;

    localparam int PIX_TOTAL = IMG_WIDTH * IMG_HEIGHT;
    localparam int AW        = $clog2(PIX_TOTAL);
    localparam int CW        = $clog2(PIX_TOTAL + 1);
    localparam int XW        = $clog2(IMG_WIDTH);
    localparam int YW        = $clog2(IMG_HEIGHT);
    localparam int QW        = XW + YW;
    localparam int SW        = CW + CNT_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CLEAR   = 4'd1;
    localparam logic [3:0] ST_SEED_RD = 4'd2;
    localparam logic [3:0] ST_SEED_WR = 4'd3;
    localparam logic [3:0] ST_POP     = 4'd4;
    localparam logic [3:0] ST_PAINT   = 4'd5;
    localparam logic [3:0] ST_NB      = 4'd6;
    localparam logic [3:0] ST_NB_CHK  = 4'd7;
    localparam logic [3:0] ST_RESP    = 4'd8;

    localparam logic [1:0] NB_LEFT  = 2'd0;
    localparam logic [1:0] NB_RIGHT = 2'd1;
    localparam logic [1:0] NB_UP    = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    function automatic logic [AW-1:0] pix_addr(input logic [XW-1:0] px,
                                               input logic [YW-1:0] py);
        return AW'(32'(py) * 32'(IMG_WIDTH) + 32'(px));
    endfunction

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_head, n_head;
    logic [CW-1:0] r_tail, n_tail;
    logic [XW-1:0] r_cx, n_cx;
    logic [YW-1:0] r_cy, n_cy;
    logic [XW-1:0] r_nx, n_nx;
    logic [YW-1:0] r_ny, n_ny;
    logic [1:0]    r_nb, n_nb;
    t_pixel        r_ref, n_ref;
    logic          r_rd_hit, n_rd_hit;
    t_count        r_count, n_count;

    t_pixel        r_img_mem [PIX_TOTAL];
    logic          r_vis_mem [PIX_TOTAL];
    logic [QW-1:0] r_q_mem   [PIX_TOTAL];
    t_pixel        r_img_rdata;
    logic          r_vis_rdata;
    logic [QW-1:0] r_q_rdata;

    logic          img_we;
    logic [AW-1:0] img_waddr;
    t_pixel        img_wdata;
    logic [AW-1:0] img_raddr;
    logic          vis_we;
    logic [AW-1:0] vis_waddr;
    logic          vis_wdata;
    logic [AW-1:0] vis_raddr;
    logic          q_we;
    logic [AW-1:0] q_waddr;
    logic [QW-1:0] q_wdata;
    logic [AW-1:0] q_raddr;

    logic          cmd_inside;
    logic [XW-1:0] cmd_x;
    logic [YW-1:0] cmd_y;
    logic [XW-1:0] q_x;
    logic [YW-1:0] q_y;
    logic [XW-1:0] nb_x;
    logic [YW-1:0] nb_y;
    logic          nb_ok;
    logic          joins;
    logic [SW-1:0] tail_ext;
    t_count        count_sat;

    tff_join_cmp u_join_cmp (
        .i_pixel     (r_img_rdata),
        .i_ref       (r_ref),
        .i_tolerance (i_tolerance),
        .o_join      (joins)
    );

    assign cmd_inside = (32'(i_cmd.x) < 32'(IMG_WIDTH)) && (32'(i_cmd.y) < 32'(IMG_HEIGHT));
    assign cmd_x      = XW'(i_cmd.x);
    assign cmd_y      = YW'(i_cmd.y);
    assign q_x        = r_q_rdata[XW-1:0];
    assign q_y        = r_q_rdata[QW-1:XW];
    assign tail_ext   = SW'(r_tail);
    assign count_sat  = (tail_ext > SW'(CNT_MAX)) ? CNT_W'(CNT_MAX) : tail_ext[CNT_W-1:0];

    always_comb begin
        nb_x  = r_cx;
        nb_y  = r_cy;
        nb_ok = 1'b0;
        case (r_nb)
            NB_LEFT: begin
                nb_x  = r_cx - XW'(1);
                nb_ok = (r_cx != '0);
            end
            NB_RIGHT: begin
                nb_x  = r_cx + XW'(1);
                nb_ok = (r_cx != XW'(IMG_WIDTH - 1));
            end
            NB_UP: begin
                nb_y  = r_cy - YW'(1);
                nb_ok = (r_cy != '0);
            end
            NB_DOWN: begin
                nb_y  = r_cy + YW'(1);
                nb_ok = (r_cy != YW'(IMG_HEIGHT - 1));
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_nx      = r_nx;
        n_ny      = r_ny;
        n_nb      = r_nb;
        n_ref     = r_ref;
        n_rd_hit  = r_rd_hit;
        n_count   = r_count;
        img_we    = 1'b0;
        img_waddr = pix_addr(cmd_x, cmd_y);
        img_wdata = i_cmd.pixel;
        img_raddr = pix_addr(cmd_x, cmd_y);
        vis_we    = 1'b0;
        vis_waddr = r_head[AW-1:0];
        vis_wdata = 1'b0;
        vis_raddr = pix_addr(nb_x, nb_y);
        q_we      = 1'b0;
        q_waddr   = r_tail[AW-1:0];
        q_wdata   = {r_ny, r_nx};
        q_raddr   = r_head[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_cmd.start) begin
                    n_rd_hit = 1'b0;
                    n_count  = '0;
                    n_cx     = cmd_x;
                    n_cy     = cmd_y;
                    n_state  = ST_RESP;
                    case (i_cmd.req_type)
                        REQ_WRITE: begin
                            img_we = cmd_inside;
                        end
                        REQ_READ: begin
                            n_rd_hit = cmd_inside;
                        end
                        REQ_FILL: begin
                            n_head = '0;
                            if (cmd_inside) begin
                                n_state = ST_CLEAR;
                            end
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                vis_we    = 1'b1;
                vis_waddr = r_head[AW-1:0];
                vis_wdata = 1'b0;
                n_head    = r_head + CW'(1);
                if (r_head[AW-1:0] == AW'(PIX_TOTAL - 1)) begin
                    n_state = ST_SEED_RD;
                end
            end
            ST_SEED_RD: begin
                img_raddr = pix_addr(r_cx, r_cy);
                n_state   = ST_SEED_WR;
            end
            ST_SEED_WR: begin
                n_ref     = r_img_rdata;
                vis_we    = 1'b1;
                vis_waddr = pix_addr(r_cx, r_cy);
                vis_wdata = 1'b1;
                q_we      = 1'b1;
                q_waddr   = '0;
                q_wdata   = {r_cy, r_cx};
                n_tail    = CW'(1);
                n_head    = '0;
                n_state   = ST_POP;
            end
            ST_POP: begin
                if (r_head == r_tail) begin
                    n_count = count_sat;
                    n_state = ST_RESP;
                end else begin
                    n_head  = r_head + CW'(1);
                    n_state = ST_PAINT;
                end
            end
            ST_PAINT: begin
                n_cx      = q_x;
                n_cy      = q_y;
                img_we    = 1'b1;
                img_waddr = pix_addr(q_x, q_y);
                img_wdata = i_fill_color;
                n_nb      = NB_LEFT;
                n_state   = ST_NB;
            end
            ST_NB: begin
                img_raddr = pix_addr(nb_x, nb_y);
                n_nx      = nb_x;
                n_ny      = nb_y;
                if (nb_ok) begin
                    n_state = ST_NB_CHK;
                end else if (r_nb == NB_DOWN) begin
                    n_state = ST_POP;
                end else begin
                    n_nb = r_nb + 2'd1;
                end
            end
            ST_NB_CHK: begin
                if (!r_vis_rdata && joins) begin
                    vis_we    = 1'b1;
                    vis_waddr = pix_addr(r_nx, r_ny);
                    vis_wdata = 1'b1;
                    q_we      = 1'b1;
                    n_tail    = r_tail + CW'(1);
                end
                if (r_nb == NB_DOWN) begin
                    n_state = ST_POP;
                end else begin
                    n_nb    = r_nb + 2'd1;
                    n_state = ST_NB;
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_nb    <= NB_LEFT;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_nb    <= n_nb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_nx     <= n_nx;
        r_ny     <= n_ny;
        r_ref    <= n_ref;
        r_rd_hit <= n_rd_hit;
        r_count  <= n_count;
    end

    always_ff @(posedge i_clk) begin
        if (img_we) begin
            r_img_mem[img_waddr] <= img_wdata;
        end
        r_img_rdata <= r_img_mem[img_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_vis_mem[vis_waddr] <= vis_wdata;
        end
        r_vis_rdata <= r_vis_mem[vis_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[q_waddr] <= q_wdata;
        end
        r_q_rdata <= r_q_mem[q_raddr];
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_rsp.done  = (r_state == ST_RESP);
    assign o_rsp.pixel = r_rd_hit ? r_img_rdata : '0;
    assign o_rsp.count = r_count;

endmodule

`default_nettype wire

### rtl/tolerance_flood_fill.sv
// Tolerance flood fill over an IMG_WIDTH x IMG_HEIGHT RGBA image held in on-chip
// memory. Every request returns exactly one response through a one-entry output
// register. A fill with a seed inside the image is accepted, then sweeps the
// visited map clear, one entry per cycle, on every such fill; then it reads and
// marks the seed, pops and paints each queued pixel, steps through its four
// neighbors and checks each one that lies inside the image, and ends with the
// final queue check and the response. A fill with a seed outside the image goes
// straight to the response with a count of zero. These steps are paced by the
// image, visited and queue memories, each with one write and one read port, and
// by the one shared color compare unit. The image store has no reset; reading a
// pixel never written returns an undefined value. Write fill_color and tolerance
// only while no request is in flight.
`default_nettype none

module tolerance_flood_fill #(
    parameter int IMG_WIDTH  = tff_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = tff_pkg::IMG_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tff_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tff_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    tff_req_if.sink                         i_req,
    tff_rsp_if.source                       o_rsp
);
    import tff_pkg::*;

    `include "tolerance_flood_fill_assert.svh"

    t_pixel r_fill_color;
    t_tol   r_tolerance;
    logic   r_out_valid;
    t_pixel r_out_pixel;
    t_count r_out_count;

    t_cmd   eng_cmd;
    t_rsp   eng_rsp;
    logic   eng_busy;

    assign i_req.ready      = !eng_busy && (!r_out_valid || o_rsp.ready);

    assign eng_cmd.start    = i_req.valid && i_req.ready;
    assign eng_cmd.req_type = i_req.req_type;
    assign eng_cmd.x        = i_req.x_coord;
    assign eng_cmd.y        = i_req.y_coord;
    assign eng_cmd.pixel    = i_req.pixel_in;

    tff_fill_engine #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (eng_cmd),
        .i_fill_color (r_fill_color),
        .i_tolerance  (r_tolerance),
        .o_busy       (eng_busy),
        .o_rsp        (eng_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_color <= '0;
            r_tolerance  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILL_COLOR: r_fill_color <= i_cfg_wdata[PIX_W-1:0];
                CFG_TOLERANCE:  r_tolerance  <= i_cfg_wdata[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_rsp.done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_rsp.done) begin
            r_out_pixel <= eng_rsp.pixel;
            r_out_count <= eng_rsp.count;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.pixel_out     = r_out_pixel;
    assign o_rsp.painted_count = r_out_count;

    `TFF_ASSERT_NEXT(a_accept_starts_engine, i_clk, i_rst_n, i_rst_n && i_req.valid && i_req.ready, eng_busy, "accepted request did not start the engine")
    `TFF_ASSERT_NOW(a_done_into_free_slot, i_clk, i_rst_n, eng_rsp.done, !r_out_valid, "engine finished while the output register was full")
    `TFF_ASSERT_NOW(a_valid_from_engine, i_clk, i_rst_n, $rose(o_rsp.valid), $past(eng_rsp.done), "response valid rose without an engine result")

endmodule

`default_nettype wire

### sim/tolerance_flood_fill_tb.sv
module tolerance_flood_fill_tb;
    import tff_pkg::*;

    localparam int IMG_W = IMG_WIDTH_DEF;
    localparam int IMG_H = IMG_HEIGHT_DEF;
    localparam int PIX_N = IMG_W * IMG_H;
    localparam int TOP_ROWS  = 8;
    localparam int BOT_ROW   = IMG_H - 2;
    localparam int LIVE_ROWS = TOP_ROWS + IMG_H - BOT_ROW;
    localparam int unsigned QUIET_LIMIT    = 200000;
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned HOLDOFF_EVERY  = 500;
    localparam t_req_type   REQ_UNUSED     = 2'd3;

    typedef struct packed {
        t_req_type kind;
        t_coord    x;
        t_coord    y;
        t_pixel    pixel;
    } pixel_request_t;

    typedef struct packed {
        t_pixel pixel;
        t_count count;
    } pixel_result_t;

    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  req_valid = 1'b0;
    pixel_request_t        req_hold  = '0;
    logic                  rsp_ready = 1'b0;

    t_pixel      image_shadow [PIX_N];
    bit          visit_mark   [PIX_N];
    int          walk_buf     [PIX_N];
    t_pixel      fill_color_cfg = '0;
    t_tol        tolerance_cfg  = '0;

    pixel_request_t pending_requests [$];
    pixel_result_t  awaited_results  [$];
    pixel_result_t  oldest_result;

    int unsigned requests_sent  = 0;
    int unsigned requests_taken = 0;
    int unsigned results_taken  = 0;
    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;
    int unsigned gap_left       = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned holdoff_left   = 0;
    int unsigned next_holdoff   = 300;
    int unsigned mode_left      = 0;
    int unsigned beat_count     = 0;
    sink_mode_t  sink_mode      = SINK_OPEN;

    tff_req_if req_if ();
    tff_rsp_if rsp_if ();

    assign req_if.valid    = req_valid;
    assign req_if.req_type = req_hold.kind;
    assign req_if.x_coord  = req_hold.x;
    assign req_if.y_coord  = req_hold.y;
    assign req_if.pixel_in = req_hold.pixel;
    assign rsp_if.ready    = rsp_ready;

    tolerance_flood_fill uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit color_near(t_pixel a, t_pixel b);
        int d;
        for (int c = 0; c < CHAN_N; c++) begin
            d = int'(a[c*CHAN_W +: CHAN_W]) - int'(b[c*CHAN_W +: CHAN_W]);
            if (d < 0) begin
                d = -d;
            end
            if (d > int'(tolerance_cfg)) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic int unsigned flood_count(int sx, int sy);
        t_pixel seed_color;
        int     head, tail, idx, nb, px, py, nx, ny;
        if (sx < 0 || sx >= IMG_W || sy < 0 || sy >= IMG_H) begin
            return 0;
        end
        head = 0;
        tail = 0;
        foreach (visit_mark[i]) begin
            visit_mark[i] = 1'b0;
        end
        idx = sy * IMG_W + sx;
        seed_color = image_shadow[idx];
        visit_mark[idx] = 1'b1;
        walk_buf[tail] = idx;
        tail++;
        while (head < tail) begin
            idx = walk_buf[head];
            head++;
            px = idx % IMG_W;
            py = idx / IMG_W;
            image_shadow[idx] = fill_color_cfg;
            for (int dir = 0; dir < 4; dir++) begin
                nx = px + ((dir == 1) ? 1 : (dir == 0) ? -1 : 0);
                ny = py + ((dir == 3) ? 1 : (dir == 2) ? -1 : 0);
                if (nx >= 0 && nx < IMG_W && ny >= 0 && ny < IMG_H) begin
                    nb = ny * IMG_W + nx;
                    if (!visit_mark[nb] && color_near(image_shadow[nb], seed_color)) begin
                        visit_mark[nb] = 1'b1;
                        walk_buf[tail] = nb;
                        tail++;
                    end
                end
            end
        end
        return (tail > CNT_MAX) ? CNT_MAX : tail;
    endfunction

    function automatic pixel_result_t compute_response(pixel_request_t r);
        pixel_result_t res;
        int            idx;
        bit            on_image;
        res = '0;
        on_image = (r.x < IMG_W) && (r.y < IMG_H);
        idx = r.y * IMG_W + r.x;
        case (r.kind)
            REQ_WRITE: begin
                if (on_image) begin
                    image_shadow[idx] = r.pixel;
                end
            end
            REQ_FILL: begin
                res.count = t_count'(flood_count(r.x, r.y));
            end
            REQ_READ: begin
                if (on_image) begin
                    res.pixel = image_shadow[idx];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_pixel shade_near(t_pixel base, int unsigned spread);
        t_pixel p;
        for (int c = 0; c < CHAN_N; c++) begin
            p[c*CHAN_W +: CHAN_W] = base[c*CHAN_W +: CHAN_W] + CHAN_W'($urandom_range(0, spread));
        end
        return p;
    endfunction

    function automatic int unsigned live_row();
        int unsigned r;
        r = $urandom_range(0, LIVE_ROWS - 1);
        return (r < TOP_ROWS) ? r : r - TOP_ROWS + BOT_ROW;
    endfunction

    task automatic queue_request(t_req_type kind, int unsigned x, int unsigned y, t_pixel pixel);
        t_pixel value;
        value = pixel;
        // keep live alpha far from the fence rows so no fill leaves its band
        if (kind == REQ_WRITE && (y < TOP_ROWS || y >= BOT_ROW)) begin
            value[CHAN_W-1] = 1'b0;
        end
        pending_requests.push_back('{kind: kind, x: t_coord'(x), y: t_coord'(y), pixel: value});
        requests_sent++;
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_FILL_COLOR: fill_color_cfg = value;
            CFG_TOLERANCE:  tolerance_cfg  = t_tol'(value);
            default: begin
            end
        endcase
    endtask

    task automatic drain_pipeline();
        while (results_taken < requests_sent) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // request driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid  <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (req_valid && req_if.ready) begin
                awaited_results.push_back(compute_response(req_hold));
                requests_taken <= requests_taken + 1;
            end
            if (!req_valid || req_if.ready) begin
                if (gap_left != 0) begin
                    req_valid <= 1'b0;
                    gap_left  <= gap_left - 1;
                end else if (pending_requests.size() != 0) begin
                    req_hold  <= pending_requests.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response ready: changing stall patterns, plus a long hold-off now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ready    <= 1'b0;
            holdoff_left <= 0;
        end else if (holdoff_left != 0) begin
            rsp_ready    <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (results_taken >= next_holdoff) begin
            rsp_ready    <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
            next_holdoff <= next_holdoff + HOLDOFF_EVERY;
        end else begin
            beat_count <= beat_count + 1;
            if (mode_left == 0) begin
                sink_mode <= sink_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 160);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (sink_mode)
                SINK_OPEN:   rsp_ready <= 1'b1;
                SINK_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
                SINK_SPARSE: rsp_ready <= ($urandom_range(0, 5) == 0);
                default:     rsp_ready <= ((beat_count % 4) != 3);
            endcase
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_ready) begin
            results_taken <= results_taken + 1;
            if (awaited_results.size() == 0) begin
                $display("%0t: response with no request pending, pixel_out %h painted_count %0d",
                         $time, rsp_if.pixel_out, rsp_if.painted_count);
                mismatch_count++;
            end else begin
                oldest_result = awaited_results.pop_front();
                if (rsp_if.pixel_out !== oldest_result.pixel) begin
                    $display("%0t: pixel_out expected %h actual %h",
                             $time, oldest_result.pixel, rsp_if.pixel_out);
                    mismatch_count++;
                end
                if (rsp_if.painted_count !== oldest_result.count) begin
                    $display("%0t: painted_count expected %0d actual %0d",
                             $time, oldest_result.count, rsp_if.painted_count);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && req_if.ready) || (rsp_if.valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_pixel      tile_shade [IMG_H/4][IMG_W/4];
        t_pixel      base;
        int unsigned goal, bw, bh, bx, by, pick;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_register(CFG_FILL_COLOR, 32'h00FF_00FF);
        set_register(CFG_TOLERANCE, 32'd2);

        // two live bands of 4x4 tiles with light noise, each fenced by a row of alpha FF
        foreach (tile_shade[ty, tx]) begin
            tile_shade[ty][tx] = $urandom();
        end
        for (int y = 0; y < IMG_H; y++) begin
            for (int x = 0; x < IMG_W; x++) begin
                if (y == TOP_ROWS || y == BOT_ROW - 1) begin
                    queue_request(REQ_WRITE, x, y, $urandom() | 32'h0000_00FF);
                end else if (y < TOP_ROWS || y >= BOT_ROW) begin
                    queue_request(REQ_WRITE, x, y, ($urandom_range(0, 3) == 0) ?
                                  shade_near(tile_shade[y/4][x/4], 2) : tile_shade[y/4][x/4]);
                end
            end
        end

        drain_pipeline();
        set_register(CFG_FILL_COLOR, 32'hA5C3_3C5A);
        set_register(CFG_TOLERANCE, 32'd5);
        queue_request(REQ_READ, 0, 0, 32'h0000_0000);
        queue_request(REQ_READ, IMG_W - 1, IMG_H - 1, 32'hFFFF_FFFF);
        queue_request(REQ_WRITE, IMG_W - 1, 0, 32'hFFFF_FFFF);
        queue_request(REQ_READ, IMG_W - 1, 0, 32'h0000_0000);
        queue_request(REQ_WRITE, 0, IMG_H - 1, 32'h0000_0000);
        queue_request(REQ_READ, 0, IMG_H - 1, 32'h0000_0000);
        queue_request(REQ_UNUSED, IMG_W - 1, IMG_H - 1, 32'hFFFF_FFFF);
        queue_request(REQ_UNUSED, 0, 0, 32'h0000_0000);
        // neighbors at or just past the tolerance, one neighbor per channel
        queue_request(REQ_WRITE, 20, 4, 32'h8080_8040);
        queue_request(REQ_WRITE, 21, 4, 32'h8580_8040);
        queue_request(REQ_WRITE, 19, 4, 32'h807A_8040);
        queue_request(REQ_WRITE, 20, 3, 32'h8080_8045);
        queue_request(REQ_WRITE, 20, 5, 32'h8080_8640);
        queue_request(REQ_FILL, 20, 4, 32'h0000_0000);
        queue_request(REQ_READ, 20, 4, 32'h0000_0000);
        queue_request(REQ_READ, 21, 4, 32'h0000_0000);
        queue_request(REQ_READ, 19, 4, 32'h0000_0000);
        queue_request(REQ_READ, 20, 5, 32'h0000_0000);
        queue_request(REQ_FILL, 0, 0, 32'h0000_0000);
        queue_request(REQ_FILL, IMG_W - 1, IMG_H - 1, 32'hFFFF_FFFF);
        queue_request(REQ_FILL, IMG_W - 1, 0, 32'h0000_0000);
        queue_request(REQ_READ, 0, 0, 32'h0000_0000);

        for (int phase = 0; phase < 4; phase++) begin
            drain_pipeline();
            set_register(CFG_FILL_COLOR,
                         (phase == 0) ? 32'h0000_0000 : ($urandom() & 32'hFFFF_FF7F));
            set_register(CFG_TOLERANCE, (phase == 0) ? 32'd0 : $urandom_range(1, 10));
            goal = requests_sent + 220;
            while (requests_sent < goal) begin
                if ($urandom_range(0, 11) == 0) begin
                    // paint a small patch near one color, fill inside it, read it back
                    bw = $urandom_range(1, 6);
                    bh = $urandom_range(1, 6);
                    bx = $urandom_range(0, IMG_W - bw);
                    by = $urandom_range(0, TOP_ROWS - bh);
                    base = $urandom();
                    for (int j = 0; j < bh; j++) begin
                        for (int i = 0; i < bw; i++) begin
                            queue_request(REQ_WRITE, bx + i, by + j,
                                          shade_near(base, tolerance_cfg + 1));
                        end
                    end
                    queue_request(REQ_FILL, bx + $urandom_range(0, bw - 1),
                                  by + $urandom_range(0, bh - 1), $urandom());
                    repeat ($urandom_range(1, 4)) begin
                        queue_request(REQ_READ, bx + $urandom_range(0, bw - 1),
                                      by + $urandom_range(0, bh - 1), $urandom());
                    end
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50) begin
                        queue_request(REQ_WRITE, $urandom_range(0, IMG_W - 1),
                                      live_row(), $urandom());
                    end else if (pick < 93) begin
                        queue_request(REQ_READ, $urandom_range(0, IMG_W - 1),
                                      live_row(), $urandom());
                    end else if (pick < 97) begin
                        queue_request(REQ_UNUSED, $urandom_range(0, IMG_W - 1),
                                      $urandom_range(0, IMG_H - 1), $urandom());
                    end else begin
                        queue_request(REQ_FILL, $urandom_range(0, IMG_W - 1),
                                      live_row(), $urandom());
                    end
                end
            end
        end

        // widest tolerance that stays inside the fences
        drain_pipeline();
        set_register(CFG_FILL_COLOR, 32'hFFFF_FF7F);
        set_register(CFG_TOLERANCE, 32'h0000_007F);
        queue_request(REQ_FILL, $urandom_range(0, IMG_W - 1), live_row(), $urandom());
        repeat (3) begin
            queue_request(REQ_READ, $urandom_range(0, IMG_W - 1), live_row(), $urandom());
        end

        drain_pipeline();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/tff_pkg.sv
rtl/tff_req_if.sv
rtl/tff_rsp_if.sv
rtl/tff_join_cmp.sv
rtl/tff_fill_engine.sv
rtl/tolerance_flood_fill.sv
sim/tolerance_flood_fill_tb.sv
